// File: sv/bbsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_pkg
// shared constants, action codes and job types of the bounded byte fifo
// ----------------------------------------------------------------------------
package bbsf_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int MAX_REQUEST = 64;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 13;
  localparam int LEN_W       = 7;
  localparam int TOT_W       = 48;
  localparam int ACT_W       = 3;
  localparam int QDEPTH      = 4;
  localparam int QPW         = $clog2(QDEPTH);

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

  localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_END    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_STATUS = 3'd5;

  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] stored_count;
    logic [CNT_W-1:0] room_left;
    logic             ended;
    logic             end_of_stream;
    logic [TOT_W-1:0] total_written;
    logic [TOT_W-1:0] total_read;
  } status_t;

  typedef struct packed {
    logic             is_data;
    logic [AW-1:0]    addr;
    logic [LEN_W-1:0] n;
    status_t          st;
  } job_t;

endpackage

`default_nettype wire

// File: sv/bbsf_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf channel interfaces
// request, response and capacity write channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface bbsf_req_if;
  import bbsf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [7:0]               data_in;
  logic [LEN_W-1:0]         length;
  modport source (output valid, action, data_in, length, input ready);
  modport sink   (input valid, action, data_in, length, output ready);
endinterface

interface bbsf_rsp_if;
  import bbsf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [7:0]               data_out;
  logic                     data_valid;
  logic                     last;
  logic                     accepted;
  logic [CNT_W-1:0]         stored_count;
  logic [CNT_W-1:0]         room_left;
  logic                     ended;
  logic                     end_of_stream;
  logic [TOT_W-1:0]         total_written;
  logic [TOT_W-1:0]         total_read;
  modport source (output valid, data_out, data_valid, last, accepted, stored_count,
                  room_left, ended, end_of_stream, total_written, total_read,
                  input ready);
  modport sink   (input valid, data_out, data_valid, last, accepted, stored_count,
                  room_left, ended, end_of_stream, total_written, total_read,
                  output ready);
endinterface

interface bbsf_cfg_if;
  import bbsf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CNT_W-1:0]         data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/bounded_byte_stream_fifo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo_unit
// byte fifo with run-time capacity, peek/read/pop requests and end of input
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    action, data_in, length
//  rsp      out  valid/ready    data_out, data_valid, last, status fields
//  cfg      in   valid/ready    data (capacity, 13 bits)
//
//  the front takes one request transaction per cycle while the job queue has room and settles all counters
//  a write request is held off while a peek or read job is still pending
//  each returned byte goes through a store read, then the output register
//  a request with a single response passes the job queue, the back job register and the output register
//  rst is synchronous; the byte store has no reset and needs no clearing pass
//  either side may stall; the four-entry job queue absorbs the difference
//
module bounded_byte_stream_fifo_unit (
  input wire logic   clk,
  input wire logic   rst,
  bbsf_req_if.sink   req,
  bbsf_rsp_if.source rsp,
  bbsf_cfg_if.sink   cfg
);
  import bbsf_pkg::*;

  // front to queue
  logic          push_valid;
  logic          push_ready;
  job_t          push_job;

  // queue to back
  logic          pop_valid;
  logic          pop_ready;
  job_t          pop_job;

  // back tells the front a peek/read has issued its last store read
  logic          data_done;

  // byte store ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // classify requests, own the pointers, totals and capacity register
  bbsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .data_done  (data_done),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  // decoupling queue of response jobs
  bbsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // circular byte store
  bbsf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // expand jobs into response transactions
  bbsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .data_done (data_done),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: sv/bbsf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/bbsf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_front
// accepts requests, updates pointers and counters, queues response jobs
// ----------------------------------------------------------------------------
module bbsf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  bbsf_req_if.sink             req,
  bbsf_cfg_if.sink             cfg,
  output      logic            push_valid,
  input  wire logic            push_ready,
  output      bbsf_pkg::job_t  push_job,
  input  wire logic            data_done,
  output      logic            mem_we,
  output      logic [bbsf_pkg::AW-1:0] mem_waddr,
  output      logic [7:0]      mem_wdata
);
  import bbsf_pkg::*;

  logic [CNT_W-1:0] capacity;
  logic [AW-1:0]    head, head_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [TOT_W-1:0] wr_total, wr_total_next;
  logic [TOT_W-1:0] rd_total, rd_total_next;
  logic             closed, closed_next;
  logic [2:0]       data_jobs;

  logic [CNT_W-1:0] cap_eff;
  logic [LEN_W-1:0] len_c;
  logic [LEN_W-1:0] n;
  logic             ok;
  logic             is_data;
  logic             write_block;
  logic             accept;

  assign cfg.ready = 1'b1;

  always_comb begin
    cap_eff = (capacity > CNT_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : capacity;
    len_c   = (req.length > LEN_W'(MAX_REQUEST)) ? LEN_W'(MAX_REQUEST) : req.length;
    n       = (CNT_W'(len_c) < fill) ? len_c : LEN_W'(fill);
    ok            = 1'b0;
    is_data       = 1'b0;
    head_next     = head;
    fill_next     = fill;
    wr_total_next = wr_total;
    rd_total_next = rd_total;
    closed_next   = closed;
    case (req.action)
      ACT_WRITE: begin
        ok = fill < cap_eff;
        if (ok) begin
          fill_next     = fill + CNT_W'(1);
          wr_total_next = wr_total + TOT_W'(1);
        end
      end
      ACT_PEEK, ACT_READ, ACT_POP: begin
        is_data = (req.action != ACT_POP) && (n != '0);
        if (req.action != ACT_PEEK) begin
          head_next     = head + AW'(n);
          fill_next     = fill - CNT_W'(n);
          rd_total_next = rd_total + TOT_W'(n);
        end
      end
      ACT_END: begin
        closed_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // writes wait until no queued peek/read still needs the old bytes
  assign write_block = (req.action == ACT_WRITE) && (data_jobs != '0);
  assign push_valid  = req.valid && !write_block;
  assign req.ready   = push_ready && !write_block;
  assign accept      = req.valid && req.ready;

  always_comb begin
    push_job.is_data          = is_data;
    push_job.addr             = head;
    push_job.n                = n;
    push_job.st.accepted      = ok;
    push_job.st.stored_count  = fill_next;
    push_job.st.room_left     = (cap_eff > fill_next) ? cap_eff - fill_next : '0;
    push_job.st.ended         = closed_next;
    push_job.st.end_of_stream = closed_next && (fill_next == '0);
    push_job.st.total_written = wr_total_next;
    push_job.st.total_read    = rd_total_next;
  end

  assign mem_we    = accept && ok;
  assign mem_waddr = AW'(CNT_W'(head) + fill);
  assign mem_wdata = req.data_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      head      <= '0;
      fill      <= '0;
      wr_total  <= '0;
      rd_total  <= '0;
      closed    <= 1'b0;
      data_jobs <= '0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      if (accept) begin
        head     <= head_next;
        fill     <= fill_next;
        wr_total <= wr_total_next;
        rd_total <= rd_total_next;
        closed   <= closed_next;
      end
      data_jobs <= data_jobs + 3'(accept && is_data) - 3'(data_done);
    end
  end

endmodule

`default_nettype wire

// File: sv/bbsf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module bbsf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output      logic           push_ready,
  input  wire bbsf_pkg::job_t push_job,
  output      logic           pop_valid,
  input  wire logic           pop_ready,
  output      bbsf_pkg::job_t pop_job
);
  import bbsf_pkg::*;

  job_t           slots [QDEPTH];
  logic [QPW-1:0] wptr;
  logic [QPW-1:0] rptr;
  logic [QPW:0]   count;
  logic           push;
  logic           pop;

  assign push_ready = count != (QPW+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPW'(1);
      end
      if (pop) begin
        rptr <= rptr + QPW'(1);
      end
      count <= count + (QPW+1)'(push) - (QPW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// File: sv/bbsf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_back
// carries out queued jobs: reads bytes from the store, drives responses
// ----------------------------------------------------------------------------
module bbsf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output      logic            pop_ready,
  input  wire bbsf_pkg::job_t  pop_job,
  output      logic            data_done,
  output      logic            mem_re,
  output      logic [bbsf_pkg::AW-1:0] mem_raddr,
  input  wire logic [7:0]      mem_rdata,
  bbsf_rsp_if.source           rsp
);
  import bbsf_pkg::*;

  job_t             job;
  logic             busy;
  logic [LEN_W-1:0] idx;
  logic             rd_pend;
  logic             rd_last;
  logic             slot_free;
  logic             issue;
  logic             last_i;

  logic             out_valid;
  logic [7:0]       out_data;
  logic             out_dvalid;
  logic             out_last;
  status_t          out_st;

  assign slot_free = !out_valid || rsp.ready;
  assign pop_ready = !busy && !rd_pend;
  assign issue     = busy && !rd_pend && slot_free;
  assign last_i    = LEN_W'(idx + LEN_W'(1)) == job.n;
  assign mem_re    = issue && job.is_data;
  assign mem_raddr = job.addr + AW'(idx);
  assign data_done = mem_re && last_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
      end else if (issue && (!job.is_data || last_i)) begin
        busy <= 1'b0;
      end
      rd_pend <= mem_re;
      if (rd_pend || (issue && !job.is_data)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job <= pop_job;
      idx <= '0;
    end else if (mem_re) begin
      idx <= idx + LEN_W'(1);
    end
    if (mem_re) begin
      rd_last <= last_i;
    end
    if (rd_pend) begin
      out_data   <= mem_rdata;
      out_dvalid <= 1'b1;
      out_last   <= rd_last;
      out_st     <= job.st;
    end else if (issue && !job.is_data) begin
      out_data   <= '0;
      out_dvalid <= 1'b0;
      out_last   <= 1'b1;
      out_st     <= job.st;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.data_out      = out_data;
  assign rsp.data_valid    = out_dvalid;
  assign rsp.last          = out_last;
  assign rsp.accepted      = out_st.accepted;
  assign rsp.stored_count  = out_st.stored_count;
  assign rsp.room_left     = out_st.room_left;
  assign rsp.ended         = out_st.ended;
  assign rsp.end_of_stream = out_st.end_of_stream;
  assign rsp.total_written = out_st.total_written;
  assign rsp.total_read    = out_st.total_read;

endmodule

`default_nettype wire

// File: sv/bbsf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_checker
// port level checks on the response channel, bound to the top level
// ----------------------------------------------------------------------------
module bbsf_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [7:0]                 rsp_data_out,
  input wire logic                       rsp_data_valid,
  input wire logic                       rsp_last,
  input wire logic                       rsp_accepted,
  input wire logic [bbsf_pkg::CNT_W-1:0] rsp_stored_count,
  input wire logic                       rsp_ended,
  input wire logic                       rsp_end_of_stream
);
  import bbsf_pkg::*;

  a_reset_idle : assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_last))
    else $error("stalled response changed");

  a_multi_data : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_data_valid)
    else $error("non-final response without a byte");

  a_accept_single : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_accepted |-> rsp_last && !rsp_data_valid)
    else $error("accepted write gave a byte or several responses");

  a_eos : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_end_of_stream |-> rsp_ended && (rsp_stored_count == '0))
    else $error("end of stream with input open or bytes held");

endmodule

bind bounded_byte_stream_fifo_unit bbsf_checker u_bbsf_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_data_out      (rsp.data_out),
  .rsp_data_valid    (rsp.data_valid),
  .rsp_last          (rsp.last),
  .rsp_accepted      (rsp.accepted),
  .rsp_stored_count  (rsp.stored_count),
  .rsp_ended         (rsp.ended),
  .rsp_end_of_stream (rsp.end_of_stream)
);

`default_nettype wire
